// ----- src/krt_pkg.sv -----
// shared types, constants and codes of the keyed record table
package krt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_LIST   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [15:0] id;
        logic [63:0] name_low;
        logic [55:0] name_high;
        logic [63:0] phone_low;
        logic [15:0] phone_high;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_rec             wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic       load;
        logic [1:0] status;
        logic       last;
        logic       use_rec;
    } t_res;

endpackage

// ----- src/krt_ram.sv -----
// generic single write, single read ram with registered read data
module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/krt_ctrl.sv -----
// sequencer: walks the table one entry at a time for search, delete shift and list
module krt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_func,
    input  logic [15:0]          i_key_id,
    input  krt_pkg::t_rec        i_rec,
    input  logic                 i_out_free,
    input  krt_pkg::t_rec        i_rd_data,
    output krt_pkg::t_ram_req    o_ram,
    output krt_pkg::t_res        o_res
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_EVAL = 6'b000100,
        S_SHRD = 6'b001000,
        S_SHWR = 6'b010000,
        S_RESP = 6'b100000
    } t_state;

    t_state                    r_state, n_state;
    logic [krt_pkg::CNT_W-1:0] r_count, n_count;
    logic [krt_pkg::CNT_W-1:0] r_idx, n_idx;
    logic [1:0]                r_func, n_func;
    logic [15:0]               r_key, n_key;
    logic [1:0]                r_status, n_status;
    logic                      r_hit, n_hit;

    logic                      w_accept;
    logic                      w_match;
    logic                      w_last_entry;
    logic [krt_pkg::CNT_W-1:0] w_idx_p1;
    logic [krt_pkg::CNT_W:0]   w_idx_p2;

    assign w_accept     = i_valid && (r_state == S_IDLE);
    assign o_stall      = (r_state != S_IDLE);
    assign w_idx_p1     = r_idx + krt_pkg::CNT_W'(1);
    assign w_idx_p2     = {1'b0, r_idx} + (krt_pkg::CNT_W + 1)'(2);
    assign w_match      = (i_rd_data.id == r_key);
    assign w_last_entry = (w_idx_p1 == r_count);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_func   = r_func;
        n_key    = r_key;
        n_status = r_status;
        n_hit    = r_hit;
        o_ram    = '0;
        o_res    = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_func = i_func;
                    n_key  = i_key_id;
                    n_hit  = 1'b0;
                    n_idx  = '0;
                    if (i_func == krt_pkg::OP_INSERT) begin
                        n_state = S_RESP;
                        if (r_count == krt_pkg::CNT_W'(krt_pkg::TABLE_DEPTH)) begin
                            n_status = krt_pkg::ST_FULL;
                        end else begin
                            n_status    = krt_pkg::ST_OK;
                            o_ram.we    = 1'b1;
                            o_ram.waddr = r_count[krt_pkg::IDX_W-1:0];
                            o_ram.wdata = i_rec;
                            n_count     = r_count + krt_pkg::CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        n_status = krt_pkg::ST_EMPTY;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = r_idx[krt_pkg::IDX_W-1:0];
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                case (r_func)
                    krt_pkg::OP_SEARCH, krt_pkg::OP_DELETE: begin
                        if (w_match) begin
                            n_status = krt_pkg::ST_OK;
                            if (r_func == krt_pkg::OP_SEARCH) begin
                                n_hit   = 1'b1;
                                n_state = S_RESP;
                            end else if (w_last_entry) begin
                                n_count = r_count - krt_pkg::CNT_W'(1);
                                n_state = S_RESP;
                            end else begin
                                n_state = S_SHRD;
                            end
                        end else if (w_last_entry) begin
                            n_status = krt_pkg::ST_NOT_FOUND;
                            n_state  = S_RESP;
                        end else begin
                            n_idx   = w_idx_p1;
                            n_state = S_READ;
                        end
                    end
                    krt_pkg::OP_LIST: begin
                        if (i_out_free) begin
                            o_res.load    = 1'b1;
                            o_res.status  = krt_pkg::ST_OK;
                            o_res.last    = w_last_entry;
                            o_res.use_rec = 1'b1;
                            if (w_last_entry) begin
                                n_state = S_IDLE;
                            end else begin
                                n_idx   = w_idx_p1;
                                n_state = S_READ;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SHRD: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = w_idx_p1[krt_pkg::IDX_W-1:0];
                n_state     = S_SHWR;
            end
            S_SHWR: begin
                // move the next entry up one place
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx[krt_pkg::IDX_W-1:0];
                o_ram.wdata = i_rd_data;
                n_idx       = w_idx_p1;
                if (w_idx_p2 < {1'b0, r_count}) begin
                    n_state = S_SHRD;
                end else begin
                    n_count = r_count - krt_pkg::CNT_W'(1);
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_out_free) begin
                    o_res.load    = 1'b1;
                    o_res.status  = r_status;
                    o_res.last    = 1'b1;
                    o_res.use_rec = r_hit;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_key    <= n_key;
        r_status <= n_status;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= krt_pkg::CNT_W'(krt_pkg::TABLE_DEPTH))
        else $error("record count above table depth");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.load |-> i_out_free)
        else $error("result loaded while output register busy");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHWR) |-> (w_idx_p1 < r_count))
        else $error("shift reads past the stored records");

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ram.we && o_ram.re))
        else $error("read and write issued in the same cycle");

endmodule

// ----- src/keyed_record_table.sv -----
// top level of the keyed record table: record ram, sequencer and output register
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------------
//  input    | i_valid / o_stall  | i_func, i_key_id, i_name_*, i_phone_*
//  output   | o_valid / i_stall  | o_status, o_rec_id, o_rec_name_*, o_rec_phone_*, o_last
//
// insert writes at the end of the table or reports full; search and delete read the entries in
// order through the read and evaluate states, and a delete moves each later entry up one place
// list gives one word per entry, one entry at a time, from the single ram read port
// reset (i_rst_n low, synchronous) empties the table; no clearing pass
// a stalled output holds the sequencer, the next input word is taken while a
// finished word still waits in the output register
module keyed_record_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_key_id,
    input  logic [63:0] i_name_low,
    input  logic [55:0] i_name_high,
    input  logic [63:0] i_phone_low,
    input  logic [15:0] i_phone_high,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_rec_id,
    output logic [63:0] o_rec_name_low,
    output logic [55:0] o_rec_name_high,
    output logic [63:0] o_rec_phone_low,
    output logic [15:0] o_rec_phone_high,
    output logic        o_last
);

    krt_pkg::t_rec     w_in_rec;
    krt_pkg::t_rec     w_rd_data;
    krt_pkg::t_rec     w_out_rec;
    krt_pkg::t_ram_req w_ram;
    krt_pkg::t_res     w_res;
    logic              w_out_free;

    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic              r_out_last;
    krt_pkg::t_rec     r_out_rec;

    assign w_in_rec.id         = i_key_id;
    assign w_in_rec.name_low   = i_name_low;
    assign w_in_rec.name_high  = i_name_high;
    assign w_in_rec.phone_low  = i_phone_low;
    assign w_in_rec.phone_high = i_phone_high;

    assign w_out_free = !r_out_valid || !i_stall;

    krt_ram #(
        .WIDTH (krt_pkg::REC_W),
        .DEPTH (krt_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rd_data)
    );

    krt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_func     (i_func),
        .i_key_id   (i_key_id),
        .i_rec      (w_in_rec),
        .i_out_free (w_out_free),
        .i_rd_data  (w_rd_data),
        .o_ram      (w_ram),
        .o_res      (w_res)
    );

    // record fields are zero unless the word carries a stored record
    assign w_out_rec = w_res.use_rec ? w_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.load) begin
            r_out_status <= w_res.status;
            r_out_last   <= w_res.last;
            r_out_rec    <= w_out_rec;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_last           = r_out_last;
    assign o_rec_id         = r_out_rec.id;
    assign o_rec_name_low   = r_out_rec.name_low;
    assign o_rec_name_high  = r_out_rec.name_high;
    assign o_rec_phone_low  = r_out_rec.phone_low;
    assign o_rec_phone_high = r_out_rec.phone_high;

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.load |=> o_valid)
        else $error("loaded result word not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !w_res.load)
        else $error("stalled result word overwritten");

    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.load && w_res.use_rec) |-> (w_res.status == krt_pkg::ST_OK))
        else $error("record returned with a failing status");

endmodule
